>>> src/sgdd_pkg.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposition package
// Shared transaction types, link type between digit cells and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdd_pkg;

   // Widths of the transaction fields.
   localparam int COEFF_W = 60;
   localparam int DIGIT_W = 64;
   localparam int INDEX_W = 6;
   localparam int LOG_BASE_W = 6;
   localparam int COUNT_W = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_INDEX_W = 1;

   // Number of digit cells in the chain, which is also the largest digit count.
   localparam int MAX_DIGITS = 64;
   localparam logic [COUNT_W-1:0] MAX_DIGITS_COUNT = 7'd64;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_BASE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT = 1'b1;

   // Values after reset.
   localparam logic [LOG_BASE_W-1:0] LOG_BASE_RESET = 6'd16;
   localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 7'd4;

   typedef struct packed {
      logic [COEFF_W-1:0] coefficient;
      logic [COEFF_W-1:0] modulus;
   } sgdd_req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [INDEX_W-1:0] digit_index;
      logic               last;
   } sgdd_rsp_type;

   // What one cell hands to the next: the running value and the modulus.
   typedef struct packed {
      logic               valid;
      logic [COEFF_W-1:0] value;
      logic [COEFF_W-1:0] modulus;
   } sgdd_link_type;

endpackage

`default_nettype wire

>>> src/sgdd_cell.sv
// ----------------------------------------------------------------------------
// Signed gadget digit cell
// Holds one coefficient at one digit position, forms that digit and passes
// the shifted running value with its carry on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdd_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  take,
   input  sgdd_pkg::sgdd_link_type              link_in,
   input  wire  [sgdd_pkg::LOG_BASE_W-1:0]      log_base,
   input  wire  [sgdd_pkg::COUNT_W-1:0]         digit_total,
   output sgdd_pkg::sgdd_link_type              link_out,
   output logic [sgdd_pkg::DIGIT_W-1:0]         digit_out,
   output logic                                 valid_out,
   output logic                                 last_out
);
   import sgdd_pkg::*;

   localparam logic [COUNT_W-1:0] POSITION = COUNT_W'(CELL_INDEX + 1);

   logic               valid_ff;
   logic [COEFF_W-1:0] value_ff;
   logic [COEFF_W-1:0] modulus_ff;

   logic [DIGIT_W-1:0] base;
   logic [DIGIT_W-1:0] mask;
   logic [DIGIT_W-1:0] low_bits;
   logic               carry;
   logic [DIGIT_W-1:0] digit;
   logic [COEFF_W-1:0] next_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= link_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff   <= link_in.value;
         modulus_ff <= link_in.modulus;
      end
   end

   always_comb begin
      base     = {{(DIGIT_W-1){1'b0}}, 1'b1} << log_base;
      mask     = base - {{(DIGIT_W-1){1'b0}}, 1'b1};
      low_bits = {{(DIGIT_W-COEFF_W){1'b0}}, value_ff} & mask;
      carry    = (log_base != '0) && low_bits[log_base - LOG_BASE_W'(1)];
      // A negative digit is folded into the modulus; the subtraction wraps.
      if (carry) begin
         digit = {{(DIGIT_W-COEFF_W){1'b0}}, modulus_ff} - (base - low_bits);
      end else begin
         digit = low_bits;
      end
      if (log_base == '0) begin
         next_value = value_ff;
      end else begin
         next_value = (value_ff >> log_base) + {{(COEFF_W-1){1'b0}}, carry};
      end
   end

   assign last_out         = valid_ff && (digit_total == POSITION);
   assign valid_out        = valid_ff;
   assign digit_out        = valid_ff ? digit : '0;
   assign link_out.valid   = valid_ff && !last_out;
   assign link_out.value   = next_value;
   assign link_out.modulus = modulus_ff;

endmodule

`default_nettype wire

>>> src/signed_gadget_digit_decompose.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposition
// Splits a coefficient into balanced signed digits in base 2^log_base.
// ----------------------------------------------------------------------------
// Each request transaction carries a coefficient and the modulus of its residue
// tower. The block answers with digit_count response transactions (at most 64),
// least significant digit first, each with its position and a last flag on the
// final one; a digit whose top bit is set is negative and is given as modulus
// minus its magnitude, with a carry into the next digit, and the carry out of
// the final digit is dropped. A coefficient yields one digit per cycle while the
// output is not stalled, and no response at all when digit_count is zero.
// The work runs through a chain of 64 digit cells: the coefficient enters the
// first cell, and it moves one cell along whenever the output is not stalled,
// while the cell it sits in forms the next digit. Only one coefficient is in the
// chain at a time, so a new coefficient waits until the previous one's final
// digit leaves; the next coefficient enters the first cell in the same cycle
// that the final digit of the previous one moves into the output register, and
// it may enter while a response waits to be taken as long as the chain is
// empty. A zero log_base makes every digit zero.
// The configuration registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_gadget_digit_decompose #(
   parameter int COEFF_BITS = 60
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  sgdd_pkg::sgdd_req_type               req_payload,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output sgdd_pkg::sgdd_rsp_type               rsp_payload,
   input  wire                                  csr_we,
   input  wire  [sgdd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [sgdd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sgdd_pkg::*;

   // Only the low COEFF_BITS bits of a coefficient take part.
   localparam logic [COEFF_W-1:0] COEFF_MASK =
      (COEFF_BITS >= COEFF_W) ? {COEFF_W{1'b1}} :
      ((COEFF_W'(1) << COEFF_BITS) - COEFF_W'(1));

   // Configuration registers.
   logic [LOG_BASE_W-1:0] log_base_ff;
   logic [COUNT_W-1:0]    digit_count_ff;
   logic [COUNT_W-1:0]    digit_total;

   // Output register.
   logic                  rsp_valid_ff;
   sgdd_rsp_type          rsp_payload_ff;
   sgdd_rsp_type          rsp_payload_in;

   // Chain of digit cells.
   sgdd_link_type         link [MAX_DIGITS+1];
   logic [DIGIT_W-1:0]    cell_digit [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] cell_valid;
   logic [MAX_DIGITS-1:0] cell_last;

   logic                  advance;
   logic                  busy;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_base_ff    <= LOG_BASE_RESET;
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOG_BASE: begin
               log_base_ff <= csr_wdata[LOG_BASE_W-1:0];
            end
            CSR_DIGIT_COUNT: begin
               digit_count_ff <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Digit counts above the chain length saturate.
   assign digit_total = (digit_count_ff > MAX_DIGITS_COUNT) ? MAX_DIGITS_COUNT
                                                             : digit_count_ff;

   // The chain moves whenever the output register is free or being emptied.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign busy    = |cell_valid;

   // A new coefficient enters when the chain is empty, or when the cell holding
   // the final digit of the current one is leaving in this cycle.
   assign req_ready = !busy || ((|cell_last) && advance);
   assign accept    = req_valid && req_ready;

   // A coefficient that yields no digits is taken and dropped.
   assign link[0].valid   = accept && (digit_total != '0);
   assign link[0].value   = req_payload.coefficient & COEFF_MASK;
   assign link[0].modulus = req_payload.modulus;

   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      sgdd_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .take        ((k == 0) ? (accept || advance) : advance),
         .link_in     (link[k]),
         .log_base    (log_base_ff),
         .digit_total (digit_total),
         .link_out    (link[k+1]),
         .digit_out   (cell_digit[k]),
         .valid_out   (cell_valid[k]),
         .last_out    (cell_last[k])
      );
   end

   // At most one cell holds a coefficient, so the response is an OR over cells.
   always_comb begin
      rsp_payload_in = '0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         rsp_payload_in.digit = rsp_payload_in.digit | cell_digit[k];
         if (cell_valid[k]) begin
            rsp_payload_in.digit_index = rsp_payload_in.digit_index | INDEX_W'(k);
         end
      end
      rsp_payload_in.last = |cell_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> src/sgdd_checker.sv
// ----------------------------------------------------------------------------
// Signed gadget digit decomposition checker
// Watches the ports of the top level for response ordering and stall rules.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdd_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input sgdd_pkg::sgdd_rsp_type               rsp_payload,
   input wire                                  csr_we,
   input wire  [sgdd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input wire  [sgdd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sgdd_pkg::*;

   logic [INDEX_W-1:0] expect_index_ff;
   logic [COUNT_W-1:0] digit_count_ff;
   logic [COUNT_W-1:0] digit_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_index_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         expect_index_ff <= rsp_payload.last ? '0 : (expect_index_ff + INDEX_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_we && (csr_index == CSR_DIGIT_COUNT)) begin
         digit_count_ff <= csr_wdata[COUNT_W-1:0];
      end
   end

   assign digit_total = (digit_count_ff > MAX_DIGITS_COUNT) ? MAX_DIGITS_COUNT
                                                             : digit_count_ff;

   // A stalled response transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // Digits of one coefficient come out in order, starting from zero.
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.digit_index == expect_index_ff)
      else $error("digit index out of sequence");

   // The last flag marks exactly the final configured digit.
   a_last_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.last ==
         ({1'b0, rsp_payload.digit_index} + COUNT_W'(1) == digit_total))
      else $error("last flag on the wrong digit");

   // With no digits configured nothing comes out.
   a_no_digits: assert property (@(posedge clock) disable iff (reset)
      (digit_total == '0) && !rsp_valid |=> !rsp_valid)
      else $error("response with zero digit count");

endmodule

bind signed_gadget_digit_decompose sgdd_checker u_sgdd_checker (.*);

`default_nettype wire
